FILE: rtl/kvtok_pkg.sv
// Package for the key = value configuration tokenizer.
// Holds the shared codes, character constants and structured types.
// No dependencies.
`default_nettype none

package kvtok_pkg;

   localparam int MAX_RESULTS = 3;

   typedef enum logic [2:0] {
      SCAN_OUTSIDE = 3'd0,
      SCAN_BARE    = 3'd1,
      SCAN_QUOTED  = 3'd2,
      SCAN_ESCAPE  = 3'd3,
      SCAN_COMMENT = 3'd4
   } scan_type;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ROLE_KEY   = 2'd0;
   localparam logic [1:0] ROLE_SEP   = 2'd1;
   localparam logic [1:0] ROLE_VALUE = 2'd2;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
   localparam logic [1:0] ERR_UNCLOSED   = 2'd2;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   typedef struct packed {
      scan_type   scan;
      logic [1:0] token_role;
      logic       token_open;
      logic       token_quoted;
      logic [1:0] sep_length;
      logic       sep_is_equals;
      logic       stopped;
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [1:0] role;
      logic       quoted;
      logic       format_error;
      logic [1:0] error_code;
      logic       last;
   } result_type;

   typedef struct packed {
      state_type                        st;
      result_type [MAX_RESULTS-1:0]     res;
      logic [1:0]                       count;
   } step_type;

endpackage

`default_nettype wire

FILE: rtl/kvtok_step.sv
// Combinational scanner step: next tokenizer state and up to three results
// for one input byte or end-of-input mark. Depends on kvtok_pkg.
`default_nettype none

module kvtok_step (
   input  wire kvtok_pkg::state_type state_cur,
   input  wire logic [7:0]           char_in,
   input  wire logic                 end_of_input,
   output kvtok_pkg::step_type       step_out
);

   function automatic kvtok_pkg::step_type f_emit(
      input kvtok_pkg::step_type w, input logic [1:0] kind, input logic [7:0] ch,
      input logic q, input logic fmt, input logic [1:0] err);
      kvtok_pkg::step_type r;
      r = w;
      if (r.count != 2'd3) begin
         r.res[r.count].kind         = kind;
         r.res[r.count].char_out     = ch;
         r.res[r.count].role         = r.st.token_role;
         r.res[r.count].quoted       = q;
         r.res[r.count].format_error = fmt;
         r.res[r.count].error_code   = err;
         r.res[r.count].last         = 1'b0;
         r.count = r.count + 2'd1;
      end
      return r;
   endfunction

   function automatic kvtok_pkg::step_type f_clear(input kvtok_pkg::step_type w);
      kvtok_pkg::step_type r;
      r = w;
      r.st.token_open    = 1'b0;
      r.st.token_quoted  = 1'b0;
      r.st.sep_length    = 2'd0;
      r.st.sep_is_equals = 1'b0;
      r.st.scan          = kvtok_pkg::SCAN_OUTSIDE;
      return r;
   endfunction

   function automatic kvtok_pkg::step_type f_put(
      input kvtok_pkg::step_type w, input logic [7:0] c);
      kvtok_pkg::step_type r;
      r = f_emit(w, kvtok_pkg::KIND_BYTE, c, w.st.token_quoted, 1'b0, kvtok_pkg::ERR_NONE);
      if (r.st.sep_length == 2'd0) begin
         r.st.sep_is_equals = (c == kvtok_pkg::CHAR_EQUALS);
      end
      if (r.st.sep_length != 2'd2) begin
         r.st.sep_length = r.st.sep_length + 2'd1;
      end
      r.st.token_open = 1'b1;
      return r;
   endfunction

   function automatic kvtok_pkg::step_type f_end(input kvtok_pkg::step_type w);
      kvtok_pkg::step_type r;
      logic                fmt;
      r = w;
      if (r.st.token_role == kvtok_pkg::ROLE_KEY && r.st.sep_length == 2'd0) begin
         // An empty key ends the parse without a result.
         r = f_clear(r);
         r.st.stopped = 1'b1;
      end else begin
         fmt = (r.st.token_role == kvtok_pkg::ROLE_SEP) &&
               !(r.st.sep_length == 2'd1 && r.st.sep_is_equals);
         r = f_emit(r, kvtok_pkg::KIND_END, 8'h00, r.st.token_quoted, fmt,
                    kvtok_pkg::ERR_NONE);
         if (r.st.token_role == kvtok_pkg::ROLE_KEY) begin
            r.st.token_role = kvtok_pkg::ROLE_SEP;
         end else if (r.st.token_role == kvtok_pkg::ROLE_SEP) begin
            r.st.token_role = kvtok_pkg::ROLE_VALUE;
         end else begin
            r.st.token_role = kvtok_pkg::ROLE_KEY;
         end
         r = f_clear(r);
      end
      return r;
   endfunction

   function automatic kvtok_pkg::step_type f_fail(
      input kvtok_pkg::step_type w, input logic [1:0] code);
      kvtok_pkg::step_type r;
      r = f_emit(w, kvtok_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b0, code);
      r.st.stopped = 1'b1;
      return r;
   endfunction

   function automatic kvtok_pkg::step_type f_plain(
      input kvtok_pkg::step_type w, input logic [7:0] c);
      kvtok_pkg::step_type r;
      r = w;
      case (c)
         kvtok_pkg::CHAR_SPACE, kvtok_pkg::CHAR_TAB,
         kvtok_pkg::CHAR_LF, kvtok_pkg::CHAR_CR: begin
            if (r.st.scan == kvtok_pkg::SCAN_BARE) r = f_end(r);
         end
         kvtok_pkg::CHAR_QUOTE: begin
            r.st.scan         = kvtok_pkg::SCAN_QUOTED;
            r.st.token_open   = 1'b1;
            r.st.token_quoted = 1'b1;
         end
         kvtok_pkg::CHAR_EQUALS: begin
            // A bare token ends first, then the equals sign is a token of its own.
            if (r.st.scan == kvtok_pkg::SCAN_BARE) r = f_end(r);
            r = f_put(r, kvtok_pkg::CHAR_EQUALS);
            r = f_end(r);
         end
         kvtok_pkg::CHAR_HASH: begin
            r.st.scan = kvtok_pkg::SCAN_COMMENT;
         end
         default: begin
            r = f_put(r, c);
            r.st.scan = kvtok_pkg::SCAN_BARE;
         end
      endcase
      return r;
   endfunction

   kvtok_pkg::step_type w;
   logic                is_line_end;

   assign is_line_end = (char_in == kvtok_pkg::CHAR_LF) || (char_in == kvtok_pkg::CHAR_CR);

   always_comb begin
      w       = '0;
      w.st    = state_cur;
      w.count = 2'd0;
      if (state_cur.stopped) begin
         w.count = 2'd0;
      end else if (end_of_input) begin
         if (w.st.scan == kvtok_pkg::SCAN_QUOTED) begin
            w = f_fail(w, kvtok_pkg::ERR_UNCLOSED);
         end else if (w.st.scan == kvtok_pkg::SCAN_ESCAPE) begin
            w = f_fail(w, kvtok_pkg::ERR_BAD_ESCAPE);
         end else begin
            if (w.st.scan == kvtok_pkg::SCAN_COMMENT) begin
               w.st.scan = w.st.token_open ? kvtok_pkg::SCAN_BARE : kvtok_pkg::SCAN_OUTSIDE;
            end
            if (w.st.scan == kvtok_pkg::SCAN_BARE) w = f_end(w);
            // At most two empty tokens bring the role back to key.
            if (!w.st.stopped && w.st.token_role != kvtok_pkg::ROLE_KEY) w = f_end(w);
            if (!w.st.stopped && w.st.token_role != kvtok_pkg::ROLE_KEY) w = f_end(w);
            w.st.stopped = 1'b1;
         end
      end else begin
         case (w.st.scan)
            kvtok_pkg::SCAN_QUOTED: begin
               if (char_in == kvtok_pkg::CHAR_QUOTE) begin
                  w = f_end(w);
               end else if (char_in == kvtok_pkg::CHAR_BACKSLASH) begin
                  w.st.scan = kvtok_pkg::SCAN_ESCAPE;
               end else if (is_line_end) begin
                  w = f_fail(w, kvtok_pkg::ERR_UNCLOSED);
               end else begin
                  w = f_put(w, char_in);
               end
            end
            kvtok_pkg::SCAN_ESCAPE: begin
               if (char_in == kvtok_pkg::CHAR_QUOTE) begin
                  w = f_put(w, kvtok_pkg::CHAR_QUOTE);
                  w.st.scan = kvtok_pkg::SCAN_QUOTED;
               end else begin
                  w = f_fail(w, kvtok_pkg::ERR_BAD_ESCAPE);
               end
            end
            kvtok_pkg::SCAN_COMMENT: begin
               if (is_line_end || char_in == kvtok_pkg::CHAR_NUL) begin
                  w.st.scan = w.st.token_open ? kvtok_pkg::SCAN_BARE : kvtok_pkg::SCAN_OUTSIDE;
                  w = f_plain(w, char_in);
               end
            end
            kvtok_pkg::SCAN_BARE: begin
               w = f_plain(w, char_in);
            end
            default: begin
               w.st.scan = kvtok_pkg::SCAN_OUTSIDE;
               w = f_plain(w, char_in);
            end
         endcase
      end
      if (w.count != 2'd0) begin
         w.res[w.count - 2'd1].last = 1'b1;
      end
   end

   assign step_out = w;

endmodule

`default_nettype wire

FILE: rtl/key_value_config_tokenizer_unit.sv
// The first result of an input transfer is offered in the cycle after it.
// Throughput: one input byte per cycle while each byte gives at most one result
// and the result port is ready; a byte with more results (up to three) holds
// the input side while the single port drains the three-entry result buffer.
// Reset (synchronous, active high) returns the scanner to outside a token with
// the key role, clears the stop flag and empties the result buffer.
`default_nettype none

module key_value_config_tokenizer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tuser,   // [0] end_of_input
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] char_out, [9:8] role, [10] quoted,
                                         // [11] format_error, [13:12] error_code,
                                         // [15:14] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last result of this input item
);

   // The scanner state advances on every accepted input transfer. The step
   // logic works out the whole effect of one byte in a single pass, and its
   // results land in a small buffer that the result port drains in order.
   kvtok_pkg::state_type   state_ff;
   kvtok_pkg::state_type   state_in;
   kvtok_pkg::step_type    step;

   kvtok_pkg::result_type [kvtok_pkg::MAX_RESULTS-1:0] buf_ff;
   kvtok_pkg::result_type [kvtok_pkg::MAX_RESULTS-1:0] buf_in;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;

   logic                   req_accept;
   logic                   rsp_accept;

   kvtok_step u_step (
      .state_cur    (state_ff),
      .char_in      (req_tdata),
      .end_of_input (req_tuser),
      .step_out     (step)
   );

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // A new byte is taken once the buffer is empty, or when its final entry
   // leaves in this same cycle, so single-result bytes stream at full rate.
   assign req_tready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      count_in = count_ff;
      if (req_accept) begin
         state_in = step.st;
         buf_in   = step.res;
         count_in = step.count;
      end else if (rsp_accept) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         count_in  = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.scan          <= kvtok_pkg::SCAN_OUTSIDE;
         state_ff.token_role    <= kvtok_pkg::ROLE_KEY;
         state_ff.token_open    <= 1'b0;
         state_ff.token_quoted  <= 1'b0;
         state_ff.sep_length    <= 2'd0;
         state_ff.sep_is_equals <= 1'b0;
         state_ff.stopped       <= 1'b0;
         count_ff               <= 2'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // The buffer entries are payload and are only read when counted as valid.
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_tdata = {2'b00, buf_ff[0].error_code, buf_ff[0].format_error,
                       buf_ff[0].quoted, buf_ff[0].role, buf_ff[0].char_out};
   assign rsp_tuser = buf_ff[0].kind;
   assign rsp_tlast = buf_ff[0].last;

endmodule

`default_nettype wire

FILE: verif/kvtok_checker.sv
// Checker for the key = value configuration tokenizer: watches both streams,
// predicts the token results of every accepted byte and compares them in order.
// Depends on kvtok_pkg for the codes, the character constants and result_type.
`timescale 1ns / 100ps

module kvtok_checker
   import kvtok_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tuser,   // [0] end_of_input
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // [7:0] char_out, [9:8] role, [10] quoted,
                                         // [11] format_error, [13:12] error_code,
                                         // [15:14] zero
   input  wire logic [1:0]  rsp_tuser,   // [1:0] kind
   input  wire logic        rsp_tlast,
   output int               failures,
   output int               pending_results
);

   // Scanner copy.
   scan_type   scan;
   logic [1:0] cur_role;
   logic       tok_open;
   logic       tok_quoted;
   logic [1:0] tok_len;
   logic       tok_first_eq;
   logic       halted;

   result_type step_results [MAX_RESULTS];
   int         step_count;
   result_type token_results [$];
   result_type oldest;
   int         mismatch_count = 0;

   assign failures = mismatch_count;

   task automatic add_result(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [1:0] role, input logic q,
                             input logic fmt, input logic [1:0] err);
      result_type r;
      if (step_count < MAX_RESULTS) begin
         r.kind         = kind;
         r.char_out     = ch;
         r.role         = role;
         r.quoted       = q;
         r.format_error = fmt;
         r.error_code   = err;
         r.last         = 1'b0;
         step_results[step_count] = r;
         step_count++;
      end
   endtask

   task automatic clear_token();
      tok_open     = 1'b0;
      tok_quoted   = 1'b0;
      tok_len      = 2'd0;
      tok_first_eq = 1'b0;
      scan         = SCAN_OUTSIDE;
   endtask

   task automatic put_token_byte(input logic [7:0] c);
      add_result(KIND_BYTE, c, cur_role, tok_quoted, 1'b0, ERR_NONE);
      if (tok_len == 2'd0) tok_first_eq = (c == CHAR_EQUALS);
      if (tok_len < 2'd2) tok_len = tok_len + 2'd1;
      tok_open = 1'b1;
   endtask

   task automatic close_token();
      logic fmt;
      if (cur_role == ROLE_KEY && tok_len == 2'd0) begin
         // An empty key ends the parse without a word.
         clear_token();
         halted = 1'b1;
      end else begin
         fmt = (cur_role == ROLE_SEP) && !(tok_len == 2'd1 && tok_first_eq);
         add_result(KIND_END, 8'd0, cur_role, tok_quoted, fmt, ERR_NONE);
         cur_role = (cur_role >= ROLE_VALUE) ? ROLE_KEY : cur_role + 2'd1;
         clear_token();
      end
   endtask

   task automatic stop_on_error(input logic [1:0] code);
      add_result(KIND_ERROR, 8'd0, cur_role, 1'b0, 1'b0, code);
      halted = 1'b1;
   endtask

   task automatic scan_plain_byte(input logic [7:0] c);
      case (c)
         CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR: begin
            if (scan == SCAN_BARE) close_token();
         end
         CHAR_QUOTE: begin
            scan       = SCAN_QUOTED;
            tok_open   = 1'b1;
            tok_quoted = 1'b1;
         end
         CHAR_EQUALS: begin
            if (scan == SCAN_BARE) close_token();
            put_token_byte(CHAR_EQUALS);
            close_token();
         end
         CHAR_HASH: scan = SCAN_COMMENT;
         default: begin
            put_token_byte(c);
            scan = SCAN_BARE;
         end
      endcase
   endtask

   task automatic tokenize_item(input logic [7:0] c, input logic eoi);
      result_type r;
      step_count = 0;
      if (!halted) begin
         if (eoi) begin
            if (scan == SCAN_QUOTED) begin
               stop_on_error(ERR_UNCLOSED);
            end else if (scan == SCAN_ESCAPE) begin
               stop_on_error(ERR_BAD_ESCAPE);
            end else begin
               if (scan == SCAN_COMMENT) scan = tok_open ? SCAN_BARE : SCAN_OUTSIDE;
               if (scan == SCAN_BARE) close_token();
               // Empty tokens fill up the triple before the stop.
               while (!halted && cur_role != ROLE_KEY) close_token();
               halted = 1'b1;
            end
         end else begin
            case (scan)
               SCAN_QUOTED: begin
                  if (c == CHAR_QUOTE) close_token();
                  else if (c == CHAR_BACKSLASH) scan = SCAN_ESCAPE;
                  else if (c == CHAR_LF || c == CHAR_CR) stop_on_error(ERR_UNCLOSED);
                  else put_token_byte(c);
               end
               SCAN_ESCAPE: begin
                  if (c == CHAR_QUOTE) begin
                     put_token_byte(CHAR_QUOTE);
                     scan = SCAN_QUOTED;
                  end else begin
                     stop_on_error(ERR_BAD_ESCAPE);
                  end
               end
               SCAN_COMMENT: begin
                  // A NUL closes the comment and then counts as a token byte.
                  if (c == CHAR_LF || c == CHAR_CR || c == CHAR_NUL) begin
                     scan = tok_open ? SCAN_BARE : SCAN_OUTSIDE;
                     scan_plain_byte(c);
                  end
               end
               SCAN_BARE: scan_plain_byte(c);
               default: begin
                  scan = SCAN_OUTSIDE;
                  scan_plain_byte(c);
               end
            endcase
         end
      end
      for (int i = 0; i < step_count; i++) begin
         r      = step_results[i];
         r.last = (i == step_count - 1);
         token_results.insert(token_results.size(), r);
      end
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_token();
         cur_role = ROLE_KEY;
         halted   = 1'b0;
         token_results.delete();
         pending_results <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (token_results.size() == 0) begin
               $error("result transfer with nothing expected: kind 0x%0h, tdata 0x%0h",
                      rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               oldest = token_results.pop_front();
               check_field("kind", 8'(oldest.kind), 8'(rsp_tuser));
               check_field("char_out", oldest.char_out, rsp_tdata[7:0]);
               check_field("role", 8'(oldest.role), 8'(rsp_tdata[9:8]));
               check_field("quoted", 8'(oldest.quoted), 8'(rsp_tdata[10]));
               check_field("format_error", 8'(oldest.format_error), 8'(rsp_tdata[11]));
               check_field("error_code", 8'(oldest.error_code), 8'(rsp_tdata[13:12]));
               check_field("tdata padding", 8'd0, 8'(rsp_tdata[15:14]));
               check_field("last", 8'(oldest.last), 8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) tokenize_item(req_tdata, req_tuser);
         pending_results <= token_results.size();
      end
   end

endmodule

FILE: verif/tb_key_value_config_tokenizer_unit.sv
// Testbench top for key_value_config_tokenizer_unit: drives configuration text
// through the byte stream, stalls the result stream and gives the verdict.
// Depends on kvtok_pkg, the tokenizer RTL and kvtok_checker.
`timescale 1ns / 100ps

module tb_key_value_config_tokenizer_unit;
   import kvtok_pkg::*;

   // The ways in which the run brings the parse to its final stop. Only one of
   // them can happen per run, as reset is applied once; the seed picks it.
   typedef enum int {
      END_PLAIN,
      END_IN_TOKEN,
      END_IN_COMMENT,
      END_COMMENT_IN_TOKEN,
      END_IN_QUOTES,
      QUOTE_BROKEN_BY_NEWLINE,
      BAD_ESCAPE_BYTE,
      BAD_ESCAPE_AT_END,
      EMPTY_KEY
   } finish_type;

   // Receiver behaviour, chosen afresh at random during the run.
   typedef enum int {
      RX_STEADY,
      RX_COIN,
      RX_MOSTLY,
      RX_BEAT
   } rx_mode_type;

   localparam int DIRECTED_ITEMS = 24;
   localparam int RANDOM_ITEMS   = 190;
   // Cycles, counted from the end of reset, over which the receiver holds off.
   localparam int HOLD_START     = 200;
   localparam int HOLD_CYCLES    = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] char_in
   logic        req_tuser = 1'b0;   // [0] end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] char_out, [9:8] role, [10] quoted,
                                    // [11] format_error, [13:12] error_code,
                                    // [15:14] zero
   logic [1:0]  rsp_tuser;          // [1:0] kind
   logic        rsp_tlast;

   int          failures;
   int          pending_results;

   // Bookkeeping of the sender: transfers made so far and what is left of
   // the current burst.
   int          bytes_sent = 0;
   int          burst_left = 0;

   int          rx_cycle = 0;
   rx_mode_type rx_mode = RX_STEADY;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   key_value_config_tokenizer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   kvtok_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .failures        (failures),
      .pending_results (pending_results)
   );

   // Receiver. It stalls on a pattern of its own and, once, holds off for a
   // long stretch so that the result buffer fills and the input side stalls.
   always @(posedge clock) begin
      if (reset) begin
         rx_cycle = 0;
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 32 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_tready <= ($urandom_range(0, 4) != 0);
               default:   rsp_tready <= (rx_cycle % 3 != 0);
            endcase
         end
      end
   end

   // One input transfer. The sender works in bursts; between bursts tvalid
   // drops for a random gap, and now and then the gap is empty so that long
   // stretches without idling also occur.
   task automatic send_item(input logic [7:0] c, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // Lowers tvalid and waits until the checker has seen every result it
   // expects. The first edge lets the last transfer reach the prediction.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // A byte that may stand in a bare token: no blank, '=', '"' or '#'.
   // The extremes of the byte range are favoured a little.
   function automatic logic [7:0] pick_bare_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0: c = 8'h00;
         1: c = 8'hFF;
         2: c = CHAR_BACKSLASH;
         default: begin
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR ||
                   c == CHAR_EQUALS || c == CHAR_QUOTE || c == CHAR_HASH);
         end
      endcase
      return c;
   endfunction

   task automatic send_blank();
      case ($urandom_range(0, 3))
         0: send_item(CHAR_SPACE, 1'b0);
         1: send_item(CHAR_TAB, 1'b0);
         2: send_item(CHAR_LF, 1'b0);
         default: send_item(CHAR_CR, 1'b0);
      endcase
   endtask

   task automatic send_bare(input int n);
      for (int i = 0; i < n; i++) send_item(pick_bare_char(), 1'b0);
   endtask

   // A quoted part with n bytes of content, some of them escaped quotes.
   // Content never holds a lone backslash, a quote, LF or CR, so the parse
   // survives it.
   task automatic send_quoted(input int n);
      logic [7:0] c;
      send_item(CHAR_QUOTE, 1'b0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_item(CHAR_BACKSLASH, 1'b0);
            send_item(CHAR_QUOTE, 1'b0);
         end else begin
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_QUOTE || c == CHAR_BACKSLASH || c == CHAR_LF ||
                   c == CHAR_CR);
            send_item(c, 1'b0);
         end
      end
      send_item(CHAR_QUOTE, 1'b0);
   endtask

   // A token of any shape. A quoted part on its own always has content, so an
   // empty key, which would stop the parse, cannot arise here.
   task automatic send_token();
      case ($urandom_range(0, 2))
         0: send_bare($urandom_range(1, 5));
         1: send_quoted($urandom_range(1, 4));
         default: begin
            send_bare($urandom_range(1, 3));
            send_quoted($urandom_range(0, 4));
         end
      endcase
   endtask

   // A comment, always closed: by LF or CR, or by a NUL that then opens or
   // extends a bare token.
   task automatic send_comment();
      logic [7:0] c;
      send_item(CHAR_HASH, 1'b0);
      repeat ($urandom_range(0, 5)) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_LF || c == CHAR_CR || c == CHAR_NUL);
         send_item(c, 1'b0);
      end
      case ($urandom_range(0, 3))
         0: send_item(CHAR_NUL, 1'b0);
         1: send_item(CHAR_CR, 1'b0);
         default: send_item(CHAR_LF, 1'b0);
      endcase
   endtask

   initial begin
      finish_type finish_kind;
      logic [7:0] c;
      bit         paused;

      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed text. It holds 0xFF and NUL as data, an '=' right after a
      // key byte (three results from one byte), a quoted part with an escaped
      // quote, a NUL that ends a comment and starts a key, a separator that is
      // not "=", a comment ended by LF and a key made of a lone '='.
      send_item("k", 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CHAR_EQUALS, 1'b0);
      send_item("v", 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item("a", 1'b0);
      send_item(CHAR_BACKSLASH, 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item(CHAR_SPACE, 1'b0);
      send_item(CHAR_HASH, 1'b0);
      send_item("z", 1'b0);
      send_item(CHAR_NUL, 1'b0);
      send_item(CHAR_TAB, 1'b0);
      send_item("a", 1'b0);
      send_item("b", 1'b0);
      send_item(CHAR_CR, 1'b0);
      send_item(CHAR_HASH, 1'b0);
      send_item("c", 1'b0);
      send_item(CHAR_LF, 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item("q", 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item(CHAR_EQUALS, 1'b0);

      // Random text: mostly well-formed key = value lines with random content,
      // the rest comments, loose tokens, embedded '=', noise and blanks.
      while (bytes_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               send_token();
               if ($urandom_range(0, 1)) send_item(CHAR_SPACE, 1'b0);
               case ($urandom_range(0, 9))
                  0: begin
                     send_item(CHAR_EQUALS, 1'b0);
                     send_item(CHAR_EQUALS, 1'b0);
                  end
                  1: send_bare($urandom_range(1, 2));
                  default: send_item(CHAR_EQUALS, 1'b0);
               endcase
               if ($urandom_range(0, 1)) send_item(CHAR_SPACE, 1'b0);
               send_token();
               if ($urandom_range(0, 3) == 0) begin
                  send_item(CHAR_SPACE, 1'b0);
                  send_comment();
               end else begin
                  send_item(($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR, 1'b0);
               end
            end
            5: send_comment();
            6: begin
               send_token();
               send_blank();
            end
            7: begin
               // An '=' inside a bare token splits it.
               send_bare($urandom_range(1, 3));
               send_item(CHAR_EQUALS, 1'b0);
               send_bare($urandom_range(1, 3));
               send_blank();
            end
            8: begin
               // Noise without quotes, closed by LF so that any comment in it
               // is over before the next piece.
               repeat ($urandom_range(1, 6)) begin
                  do c = 8'($urandom_range(0, 255));
                  while (c == CHAR_QUOTE);
                  send_item(c, 1'b0);
               end
               send_item(CHAR_LF, 1'b0);
            end
            default: repeat ($urandom_range(1, 3)) send_blank();
         endcase
         // Once, the sender waits for every expected result before going on.
         if (!paused && bytes_sent >= DIRECTED_ITEMS + 150) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      // The final stop of the parse.
      finish_kind = finish_type'($urandom_range(0, 8));
      case (finish_kind)
         END_PLAIN: send_item(8'($urandom_range(0, 255)), 1'b1);
         END_IN_TOKEN: begin
            send_bare($urandom_range(1, 3));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         END_IN_COMMENT: begin
            send_item(CHAR_HASH, 1'b0);
            send_item("c", 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         END_COMMENT_IN_TOKEN: begin
            send_bare($urandom_range(1, 3));
            send_item(CHAR_HASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         END_IN_QUOTES: begin
            send_item(CHAR_QUOTE, 1'b0);
            send_item("a", 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         QUOTE_BROKEN_BY_NEWLINE: begin
            send_item(CHAR_QUOTE, 1'b0);
            send_item("a", 1'b0);
            send_item(($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR, 1'b0);
         end
         BAD_ESCAPE_BYTE: begin
            send_item(CHAR_QUOTE, 1'b0);
            send_item(CHAR_BACKSLASH, 1'b0);
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_QUOTE);
            send_item(c, 1'b0);
         end
         BAD_ESCAPE_AT_END: begin
            send_item(CHAR_QUOTE, 1'b0);
            send_item(CHAR_BACKSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         default: begin
            // Three empty quoted tokens if no token is open: whichever role is
            // current, one lands on the key role and ends the parse quietly.
            repeat (6) send_item(CHAR_QUOTE, 1'b0);
         end
      endcase

      // Once stopped, the block gives no result for anything until reset.
      send_item(8'($urandom_range(0, 255)), 1'b1);
      repeat (3) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/kvtok_pkg.sv
rtl/kvtok_step.sv
rtl/key_value_config_tokenizer_unit.sv
verif/kvtok_checker.sv
verif/tb_key_value_config_tokenizer_unit.sv
